// ----- rtl/core/best_fit_heap_allocator_core_assert.svh -----
// Assertion macros shared by the allocator core.
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
`define BFHA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define BFHA_ASSERT_IMP(label, ante, cons)
`define BFHA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/bfha_pkg.sv -----
package bfha_pkg;

  localparam int unsigned HEAP_BYTES  = 1048576;
  localparam int unsigned CHUNK_BYTES = 4096;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned EXT_W       = WORD_W + 1;
  localparam int unsigned IMG_WORDS   = HEAP_BYTES / 8;
  localparam int unsigned IDX_W       = $clog2(IMG_WORDS);
  localparam int unsigned HEND_W      = $clog2(HEAP_BYTES + 1);
  localparam int unsigned WALK_LIMIT  = HEAP_BYTES / 32 + 1;
  localparam int unsigned STEP_W      = $clog2(WALK_LIMIT + 1);
  localparam int unsigned REQ_SIZE_W  = 21;
  localparam int unsigned ADDR_W      = 20;
  localparam int unsigned CNT_W       = 21;

  localparam logic [WORD_W-1:0] MIN_BLOCK     = WORD_W'(32);
  localparam logic [WORD_W-1:0] CHUNK_RND     = WORD_W'(((CHUNK_BYTES + 15) / 16) * 16);
  localparam logic [WORD_W-1:0] INIT_BLOCK    = WORD_W'(4096);
  localparam logic [WORD_W-1:0] PROLOGUE_SIZE = WORD_W'(16);
  localparam logic [WORD_W-1:0] FREE_HEAD_RST = WORD_W'(32);
  localparam logic [HEND_W-1:0] HEAP_END_RST  = HEND_W'(4128);
  localparam logic [CNT_W-1:0]  HEAP_CNT_RST  = CNT_W'(4096);

  localparam logic [IDX_W-1:0] IDX_PRO_HDR  = IDX_W'(8 / 8);
  localparam logic [IDX_W-1:0] IDX_PRO_FTR  = IDX_W'(16 / 8);
  localparam logic [IDX_W-1:0] IDX_FREE_HDR = IDX_W'(24 / 8);
  localparam logic [IDX_W-1:0] IDX_FREE_FTR = IDX_W'(4112 / 8);
  localparam logic [IDX_W-1:0] IDX_EPILOGUE = IDX_W'(4120 / 8);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE,
    ST_BF_CHK, ST_BF_SZ, ST_BF_NX, ST_BF_END,
    ST_GR_CHK, ST_GR_PA, ST_GR_EPI,
    ST_CV_HDR, ST_CV_DEC, ST_CV_NXR, ST_CV_NXW, ST_CV_REM,
    ST_FIN_RD, ST_FIN_CNT,
    ST_FR_HDR, ST_FR_CHK, ST_FR_NXR, ST_FR_NXW,
    ST_MF_HDR, ST_MF_SZ, ST_MF_CASE, ST_MF_PA, ST_MF_PS, ST_MF_AFT,
    ST_MF_PPA1, ST_MF_NS, ST_MF_PRD, ST_MF_PPA2, ST_MF_DONE,
    ST_UL_ENT, ST_UL_P, ST_UL_N, ST_UL_W,
    ST_TG1, ST_TG2, ST_PU1, ST_PU2, ST_PU3,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_addr;
    logic              ok;
    logic [CNT_W-1:0]  user_bytes;
    logic [CNT_W-1:0]  heap_bytes;
  } result_t;

  function automatic logic [WORD_W-1:0] make_tag(input logic [WORD_W-1:0] size,
                                                 input logic pa, input logic a);
    return {size[WORD_W-1:3], 1'b0, pa, a};
  endfunction

  function automatic logic [IDX_W-1:0] word_idx(input logic [WORD_W-1:0] off);
    return off[IDX_W+2:3];
  endfunction

  function automatic logic [WORD_W-1:0] init_word(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      IDX_PRO_HDR, IDX_PRO_FTR:   w = make_tag(PROLOGUE_SIZE, 1'b1, 1'b1);
      IDX_FREE_HDR, IDX_FREE_FTR: w = make_tag(INIT_BLOCK, 1'b1, 1'b0);
      IDX_EPILOGUE:               w = make_tag('0, 1'b0, 1'b1);
      default:                    w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/bfha_req_if.sv -----
interface bfha_req_if import bfha_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [REQ_SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0]     block_addr;

  modport source (output valid, output req_type, output req_size, output block_addr,
                  input ready);
  modport sink (input valid, input req_type, input req_size, input block_addr,
                output ready);
endinterface

// ----- rtl/core/bfha_rsp_if.sv -----
interface bfha_rsp_if import bfha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] payload_addr;
  logic              ok;
  logic [CNT_W-1:0]  user_bytes;
  logic [CNT_W-1:0]  heap_bytes;

  modport source (output valid, output payload_addr, output ok, output user_bytes,
                  output heap_bytes, input ready);
  modport sink (input valid, input payload_addr, input ok, input user_bytes,
                input heap_bytes, output ready);
endinterface

// ----- rtl/core/bfha_ram.sv -----
module bfha_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end
endmodule

// ----- rtl/core/bfha_ctrl.sv -----
`include "best_fit_heap_allocator_core_assert.svh"
module bfha_ctrl import bfha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bfha_req_if.sink          in_req,
  output mem_req_t          mem,
  input  logic [WORD_W-1:0] rdata,
  input  logic              res_free,
  output logic              res_valid,
  output result_t           res
);
  st_t               state_r, state_nxt, ret_r, ret_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic              type_r, type_nxt;
  logic [WORD_W-1:0] asize_r, asize_nxt, bp_r, bp_nxt, size_r, size_nxt;
  logic [WORD_W-1:0] nxt_r, nxt_nxt, ps_r, ps_nxt, ns_r, ns_nxt, prv_r, prv_nxt;
  logic              pa_r, pa_nxt, na_r, na_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt, best_r, best_nxt, best_sz_r, best_sz_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [WORD_W-1:0] u_r, u_nxt, p_r, p_nxt, n_r, n_nxt;
  logic [WORD_W-1:0] t_bp_r, t_bp_nxt, t_size_r, t_size_nxt;
  logic              t_pa_r, t_pa_nxt, t_push_r, t_push_nxt;
  logic [WORD_W-1:0] free_head_r, free_head_nxt;
  logic [HEND_W-1:0] heap_end_r, heap_end_nxt;
  logic [CNT_W-1:0]  user_r, user_nxt, heap_cnt_r, heap_cnt_nxt;
  logic [WORD_W-1:0] pay_r, pay_nxt;
  logic              ok_r, ok_nxt;

  logic [WORD_W-1:0] rd_sz, asize_rnd, asize_in, gsize, free_tag;
  logic              bf_more, bf_take, grow_ok, fr_addr_ok, fr_hdr_ok, cv_whole;

  assign rd_sz     = {rdata[WORD_W-1:3], 3'b000};
  assign asize_rnd = (WORD_W'(in_req.req_size) + WORD_W'(23)) & ~WORD_W'(15);
  assign asize_in  = (asize_rnd < MIN_BLOCK) ? MIN_BLOCK : asize_rnd;
  assign gsize     = (asize_r > CHUNK_RND) ? asize_r : CHUNK_RND;
  assign bf_more   = (cur_r != '0) && (steps_r < STEP_W'(WALK_LIMIT));
  assign bf_take   = (rd_sz >= asize_r) && ((best_r == '0) || (rd_sz < best_sz_r));
  assign grow_ok   = (EXT_W'(heap_end_r) + EXT_W'(gsize)) <= EXT_W'(HEAP_BYTES);
  assign fr_addr_ok = (bp_r[3:0] == 4'd0) && (bp_r >= MIN_BLOCK)
                      && (bp_r < WORD_W'(heap_end_r));
  assign fr_hdr_ok = rdata[0] && (rd_sz >= MIN_BLOCK)
                     && ((EXT_W'(bp_r) + EXT_W'(rd_sz)) <= EXT_W'(heap_end_r));
  assign cv_whole  = rd_sz < (asize_r + MIN_BLOCK);
  assign free_tag  = make_tag(t_size_r, t_pa_r, 1'b0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_r == IDX_W'(IMG_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_req.valid) begin
          if (in_req.req_type == REQ_FREE) state_nxt = ST_FR_HDR;
          else if (in_req.req_size == '0) state_nxt = ST_DONE;
          else state_nxt = ST_BF_CHK;
        end
      end
      ST_BF_CHK:  state_nxt = bf_more ? ST_BF_SZ : ST_BF_END;
      ST_BF_SZ:   state_nxt = ST_BF_NX;
      ST_BF_NX:   state_nxt = ST_BF_CHK;
      ST_BF_END:  state_nxt = (best_r != '0) ? ST_CV_HDR : ST_GR_CHK;
      ST_GR_CHK:  state_nxt = grow_ok ? ST_GR_PA : ST_DONE;
      ST_GR_PA:   state_nxt = ST_TG1;
      ST_GR_EPI:  state_nxt = ST_MF_HDR;
      ST_CV_HDR:  state_nxt = ST_CV_DEC;
      ST_CV_DEC:  state_nxt = ST_UL_ENT;
      ST_CV_NXR:  state_nxt = ST_CV_NXW;
      ST_CV_NXW:  state_nxt = ST_FIN_RD;
      ST_CV_REM:  state_nxt = ST_TG1;
      ST_FIN_RD:  state_nxt = ST_FIN_CNT;
      ST_FIN_CNT: state_nxt = ST_DONE;
      ST_FR_HDR:  state_nxt = fr_addr_ok ? ST_FR_CHK : ST_DONE;
      ST_FR_CHK:  state_nxt = fr_hdr_ok ? ST_TG1 : ST_DONE;
      ST_FR_NXR:  state_nxt = ST_FR_NXW;
      ST_FR_NXW:  state_nxt = ST_MF_HDR;
      ST_MF_HDR:  state_nxt = ST_MF_SZ;
      ST_MF_SZ:   state_nxt = ST_MF_CASE;
      ST_MF_CASE: begin
        if (pa_r && rdata[0]) state_nxt = ST_TG1;
        else if (pa_r) state_nxt = ST_UL_ENT;
        else state_nxt = ST_MF_PS;
      end
      ST_MF_PA:   state_nxt = ST_TG1;
      ST_MF_PS:   state_nxt = ST_UL_ENT;
      ST_MF_AFT:  state_nxt = na_r ? ST_MF_PPA1 : ST_MF_NS;
      ST_MF_PPA1: state_nxt = ST_TG1;
      ST_MF_NS:   state_nxt = ST_UL_ENT;
      ST_MF_PRD:  state_nxt = ST_MF_PPA2;
      ST_MF_PPA2: state_nxt = ST_TG1;
      ST_MF_DONE: state_nxt = (type_r == REQ_ALLOC) ? ST_CV_HDR : ST_DONE;
      ST_UL_ENT:  state_nxt = (free_head_r == '0) ? ret_r : ST_UL_P;
      ST_UL_P:    state_nxt = ST_UL_N;
      ST_UL_N:    state_nxt = ST_UL_W;
      ST_UL_W:    state_nxt = ret_r;
      ST_TG1:     state_nxt = ST_TG2;
      ST_TG2:     state_nxt = t_push_r ? ST_PU1 : ret_r;
      ST_PU1:     state_nxt = ST_PU2;
      ST_PU2:     state_nxt = ST_PU3;
      ST_PU3:     state_nxt = ret_r;
      ST_DONE:    if (res_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt = ret_r;         clr_nxt = clr_r;         type_nxt = type_r;
    asize_nxt = asize_r;     bp_nxt = bp_r;           size_nxt = size_r;
    nxt_nxt = nxt_r;         ps_nxt = ps_r;           ns_nxt = ns_r;
    prv_nxt = prv_r;         pa_nxt = pa_r;           na_nxt = na_r;
    cur_nxt = cur_r;         best_nxt = best_r;       best_sz_nxt = best_sz_r;
    steps_nxt = steps_r;     u_nxt = u_r;             p_nxt = p_r;
    n_nxt = n_r;             t_bp_nxt = t_bp_r;       t_size_nxt = t_size_r;
    t_pa_nxt = t_pa_r;       t_push_nxt = t_push_r;   free_head_nxt = free_head_r;
    heap_end_nxt = heap_end_r; user_nxt = user_r;     heap_cnt_nxt = heap_cnt_r;
    pay_nxt = pay_r;         ok_nxt = ok_r;
    case (state_r)
      ST_CLEAR: clr_nxt = clr_r + IDX_W'(1);
      ST_IDLE: begin
        if (in_req.valid) begin
          type_nxt    = in_req.req_type;
          bp_nxt      = WORD_W'(in_req.block_addr);
          asize_nxt   = asize_in;
          cur_nxt     = free_head_r;
          best_nxt    = '0;
          best_sz_nxt = '0;
          steps_nxt   = '0;
          pay_nxt     = '0;
          ok_nxt      = 1'b0;
        end
      end
      ST_BF_SZ: begin
        if (bf_take) begin
          best_nxt    = cur_r;
          best_sz_nxt = rd_sz;
        end
      end
      ST_BF_NX: begin
        cur_nxt   = rdata;
        steps_nxt = steps_r + STEP_W'(1);
      end
      ST_BF_END: if (best_r != '0) bp_nxt = best_r;
      ST_GR_CHK: begin
        if (grow_ok) begin
          bp_nxt   = WORD_W'(heap_end_r);
          size_nxt = gsize;
        end
      end
      ST_GR_PA: begin
        t_bp_nxt = bp_r;  t_size_nxt = size_r;  t_pa_nxt = rdata[1];  t_push_nxt = 1'b0;
        ret_nxt  = ST_GR_EPI;
      end
      ST_GR_EPI: begin
        heap_end_nxt = heap_end_r + HEND_W'(size_r);
        heap_cnt_nxt = heap_cnt_r + CNT_W'(size_r);
      end
      ST_CV_DEC: begin
        size_nxt = rd_sz;
        nxt_nxt  = bp_r + rd_sz;
        u_nxt    = bp_r;
        ret_nxt  = cv_whole ? ST_CV_NXR : ST_CV_REM;
      end
      ST_CV_REM: begin
        t_bp_nxt = bp_r + asize_r;  t_size_nxt = size_r - asize_r;
        t_pa_nxt = 1'b1;  t_push_nxt = 1'b1;
        ret_nxt  = ST_FIN_RD;
      end
      ST_FIN_CNT: begin
        user_nxt = CNT_W'(WORD_W'(user_r) + rd_sz - WORD_W'(8));
        pay_nxt  = bp_r;
        ok_nxt   = 1'b1;
      end
      ST_FR_CHK: begin
        if (fr_hdr_ok) begin
          size_nxt = rd_sz;
          nxt_nxt  = bp_r + rd_sz;
          t_bp_nxt = bp_r;  t_size_nxt = rd_sz;  t_pa_nxt = rdata[1];  t_push_nxt = 1'b0;
          ret_nxt  = ST_FR_NXR;
        end
      end
      ST_FR_NXW: user_nxt = CNT_W'(WORD_W'(user_r) - (size_r - WORD_W'(8)));
      ST_MF_SZ: begin
        size_nxt = rd_sz;
        pa_nxt   = rdata[1];
        nxt_nxt  = bp_r + rd_sz;
      end
      ST_MF_CASE: begin
        na_nxt = rdata[0];
        ns_nxt = rd_sz;
        if (pa_r && rdata[0]) begin
          t_bp_nxt = bp_r;  t_size_nxt = size_r;  t_pa_nxt = 1'b1;  t_push_nxt = 1'b1;
          ret_nxt  = ST_MF_DONE;
        end else if (pa_r) begin
          u_nxt   = nxt_r;
          ret_nxt = ST_MF_PA;
        end
      end
      ST_MF_PA: begin
        t_bp_nxt = bp_r;  t_size_nxt = size_r + ns_r;  t_pa_nxt = 1'b1;  t_push_nxt = 1'b1;
        ret_nxt  = ST_MF_DONE;
      end
      ST_MF_PS: begin
        ps_nxt  = rd_sz;
        prv_nxt = bp_r - rd_sz;
        u_nxt   = bp_r - rd_sz;
        ret_nxt = ST_MF_AFT;
      end
      ST_MF_PPA1: begin
        t_bp_nxt = prv_r;  t_size_nxt = size_r + ps_r;  t_pa_nxt = rdata[1];
        t_push_nxt = 1'b1;
        ret_nxt  = ST_MF_DONE;
      end
      ST_MF_NS: begin
        ns_nxt  = rd_sz;
        u_nxt   = nxt_r;
        ret_nxt = ST_MF_PRD;
      end
      ST_MF_PPA2: begin
        t_bp_nxt = prv_r;  t_size_nxt = size_r + ps_r + ns_r;  t_pa_nxt = rdata[1];
        t_push_nxt = 1'b1;
        ret_nxt  = ST_MF_DONE;
      end
      ST_MF_DONE: begin
        if (type_r == REQ_ALLOC) bp_nxt = t_bp_r;
        else ok_nxt = 1'b1;
      end
      ST_UL_P: p_nxt = rdata;
      ST_UL_N: begin
        n_nxt = rdata;
        if (p_r == '0) free_head_nxt = rdata;
      end
      ST_PU3: free_head_nxt = t_bp_r;
      default: ;
    endcase
  end

  always_comb begin
    mem       = '0;
    res_valid = (state_r == ST_DONE) && res_free;
    res       = '{payload_addr: pay_r[ADDR_W-1:0], ok: ok_r, user_bytes: user_r,
                  heap_bytes: heap_cnt_r};
    in_req.ready = (state_r == ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        mem.we = 1'b1;  mem.waddr = clr_r;  mem.wdata = init_word(clr_r);
      end
      ST_BF_CHK:  mem.raddr = word_idx(cur_r - WORD_W'(8));
      ST_BF_SZ:   mem.raddr = word_idx(cur_r + WORD_W'(8));
      ST_GR_CHK:  mem.raddr = word_idx(WORD_W'(heap_end_r) - WORD_W'(8));
      ST_GR_EPI: begin
        mem.we    = 1'b1;
        mem.waddr = word_idx(bp_r + size_r - WORD_W'(8));
        mem.wdata = make_tag('0, 1'b0, 1'b1);
      end
      ST_CV_HDR:  mem.raddr = word_idx(bp_r - WORD_W'(8));
      ST_CV_DEC: begin
        mem.we    = 1'b1;
        mem.waddr = word_idx(bp_r - WORD_W'(8));
        mem.wdata = cv_whole ? (rdata | WORD_W'(1)) : make_tag(asize_r, rdata[1], 1'b1);
      end
      ST_CV_NXR:  mem.raddr = word_idx(nxt_r - WORD_W'(8));
      ST_CV_NXW: begin
        mem.we = 1'b1;  mem.waddr = word_idx(nxt_r - WORD_W'(8));
        mem.wdata = rdata | WORD_W'(2);
      end
      ST_FIN_RD:  mem.raddr = word_idx(bp_r - WORD_W'(8));
      ST_FR_HDR:  mem.raddr = word_idx(bp_r - WORD_W'(8));
      ST_FR_NXR:  mem.raddr = word_idx(nxt_r - WORD_W'(8));
      ST_FR_NXW: begin
        mem.we = 1'b1;  mem.waddr = word_idx(nxt_r - WORD_W'(8));
        mem.wdata = rdata & ~WORD_W'(2);
      end
      ST_MF_HDR:  mem.raddr = word_idx(bp_r - WORD_W'(8));
      ST_MF_SZ:   mem.raddr = word_idx(bp_r + rd_sz - WORD_W'(8));
      ST_MF_CASE: mem.raddr = word_idx(bp_r - WORD_W'(16));
      ST_MF_AFT:  mem.raddr = na_r ? word_idx(prv_r - WORD_W'(8))
                                   : word_idx(nxt_r - WORD_W'(8));
      ST_MF_PRD:  mem.raddr = word_idx(prv_r - WORD_W'(8));
      ST_UL_ENT:  mem.raddr = word_idx(u_r);
      ST_UL_P:    mem.raddr = word_idx(u_r + WORD_W'(8));
      ST_UL_N: begin
        mem.we = (p_r != '0);  mem.waddr = word_idx(p_r + WORD_W'(8));  mem.wdata = rdata;
      end
      ST_UL_W: begin
        mem.we = (n_r != '0);  mem.waddr = word_idx(n_r);  mem.wdata = p_r;
      end
      ST_TG1: begin
        mem.we = 1'b1;  mem.waddr = word_idx(t_bp_r - WORD_W'(8));  mem.wdata = free_tag;
      end
      ST_TG2: begin
        mem.we = 1'b1;  mem.waddr = word_idx(t_bp_r + t_size_r - WORD_W'(16));
        mem.wdata = free_tag;
      end
      ST_PU1: begin
        mem.we = 1'b1;  mem.waddr = word_idx(t_bp_r);  mem.wdata = '0;
      end
      ST_PU2: begin
        mem.we = 1'b1;  mem.waddr = word_idx(t_bp_r + WORD_W'(8));  mem.wdata = free_head_r;
      end
      ST_PU3: begin
        mem.we = (free_head_r != '0);  mem.waddr = word_idx(free_head_r);  mem.wdata = t_bp_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_IDLE;
      clr_r       <= '0;
      free_head_r <= FREE_HEAD_RST;
      heap_end_r  <= HEAP_END_RST;
      user_r      <= '0;
      heap_cnt_r  <= HEAP_CNT_RST;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      heap_end_r  <= heap_end_nxt;
      user_r      <= user_nxt;
      heap_cnt_r  <= heap_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;   asize_r <= asize_nxt;   bp_r <= bp_nxt;
    size_r <= size_nxt;   nxt_r <= nxt_nxt;       ps_r <= ps_nxt;
    ns_r <= ns_nxt;       prv_r <= prv_nxt;       pa_r <= pa_nxt;
    na_r <= na_nxt;       cur_r <= cur_nxt;       best_r <= best_nxt;
    best_sz_r <= best_sz_nxt;  steps_r <= steps_nxt;  u_r <= u_nxt;
    p_r <= p_nxt;         n_r <= n_nxt;           t_bp_r <= t_bp_nxt;
    t_size_r <= t_size_nxt;  t_pa_r <= t_pa_nxt;  t_push_r <= t_push_nxt;
    pay_r <= pay_nxt;     ok_r <= ok_nxt;
  end

  `BFHA_ASSERT_IMP(a_heap_end_bound, 1'b1, WORD_W'(heap_end_r) <= WORD_W'(HEAP_BYTES))
  `BFHA_ASSERT_IMP(a_heap_end_align, 1'b1, heap_end_r[3:0] == 4'd0)
  `BFHA_ASSERT_NXT(a_accept_leaves_idle, in_req.valid && in_req.ready, state_r != ST_IDLE)
endmodule

// ----- rtl/core/best_fit_heap_allocator_core.sv -----
// Channel   Direction  Payload
// in_req    sink       req_type, req_size, block_addr
// out_rsp   source     payload_addr, ok, user_bytes, heap_bytes
//
// After reset the heap image is initialised one word per cycle, all 131072 words,
// before the first request transaction is taken.
// A free is either rejected or merges the freed block with its free neighbours.
// An allocate walks the free list for the smallest block that fits and grows the heap
// when none fits; a zero-size allocate goes straight to the result.
// One request is in work at a time; a finished result waits in the output register.
module best_fit_heap_allocator_core import bfha_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  bfha_req_if.sink   in_req,
  bfha_rsp_if.source out_rsp
);
  mem_req_t          mem;
  logic [WORD_W-1:0] rdata;
  result_t           res, out_data_r, out_data_nxt;
  logic              res_valid, res_free, out_valid_r, out_valid_nxt;

  bfha_ram #(.DEPTH(IMG_WORDS), .WIDTH(WORD_W)) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  bfha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .mem       (mem),
    .rdata     (rdata),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.payload_addr = out_data_r.payload_addr;
  assign out_rsp.ok           = out_data_r.ok;
  assign out_rsp.user_bytes   = out_data_r.user_bytes;
  assign out_rsp.heap_bytes   = out_data_r.heap_bytes;
endmodule

// ----- bench/best_fit_heap_allocator_core_tb.sv -----
`timescale 1ns / 100ps

module best_fit_heap_allocator_core_tb import bfha_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1920;

  logic clk;
  logic rst_n;

  bfha_req_if in_req ();
  bfha_rsp_if out_rsp ();

  best_fit_heap_allocator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_rsp(out_rsp.source)
  );

  logic [WORD_W-1:0] heap_words [0:IMG_WORDS-1];
  logic [WORD_W-1:0] list_head;
  logic [WORD_W-1:0] brk_end;
  logic [CNT_W-1:0]  live_bytes;
  logic [CNT_W-1:0]  grown_bytes;

  result_t     alloc_results [$];
  logic [31:0] live_blocks [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned rsp_hold;
  bit          calm;

  always #5 clk = ~clk;

  function automatic logic [WORD_W-1:0] heap_rd(input logic [WORD_W-1:0] off);
    return heap_words[off[IDX_W+2:3]];
  endfunction

  function automatic void heap_wr(input logic [WORD_W-1:0] off, input logic [WORD_W-1:0] v);
    heap_words[off[IDX_W+2:3]] = v;
  endfunction

  function automatic logic [WORD_W-1:0] btag(input logic [WORD_W-1:0] size, input logic pa,
                                             input logic a);
    return {size[WORD_W-1:3], 1'b0, pa, a};
  endfunction

  function automatic logic [WORD_W-1:0] block_len(input logic [WORD_W-1:0] bp);
    return heap_rd(bp - 8) & ~32'd7;
  endfunction

  function automatic logic lower_taken(input logic [WORD_W-1:0] bp);
    logic [WORD_W-1:0] h;
    h = heap_rd(bp - 8);
    return h[1];
  endfunction

  function automatic void mark_free(input logic [WORD_W-1:0] bp, input logic [WORD_W-1:0] size,
                                    input logic pa);
    heap_wr(bp - 8, btag(size, pa, 1'b0));
    heap_wr(bp + size - 16, btag(size, pa, 1'b0));
  endfunction

  function automatic void push_free(input logic [WORD_W-1:0] bp);
    heap_wr(bp, '0);
    heap_wr(bp + 8, list_head);
    if (list_head != 0) heap_wr(list_head, bp);
    list_head = bp;
  endfunction

  function automatic void unlink_free(input logic [WORD_W-1:0] bp);
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] n;
    if (list_head == 0) return;
    p = heap_rd(bp);
    n = heap_rd(bp + 8);
    if (p != 0) heap_wr(p + 8, n);
    else list_head = n;
    if (n != 0) heap_wr(n, p);
  endfunction

  function automatic logic [WORD_W-1:0] coalesce(input logic [WORD_W-1:0] bp);
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] nxt;
    logic [WORD_W-1:0] ps;
    logic [WORD_W-1:0] ns;
    logic [WORD_W-1:0] prv;
    logic [WORD_W-1:0] nh;
    logic              pa;
    logic              na;
    size = block_len(bp);
    pa = lower_taken(bp);
    nxt = bp + size;
    nh = heap_rd(nxt - 8);
    na = nh[0];
    if (pa && na) begin
      mark_free(bp, size, 1'b1);
      push_free(bp);
      return bp;
    end
    if (pa) begin
      ns = block_len(nxt);
      unlink_free(nxt);
      mark_free(bp, size + ns, 1'b1);
      push_free(bp);
      return bp;
    end
    ps = heap_rd(bp - 16) & ~32'd7;
    prv = bp - ps;
    unlink_free(prv);
    if (na) begin
      mark_free(prv, size + ps, lower_taken(prv));
    end else begin
      ns = block_len(nxt);
      unlink_free(nxt);
      mark_free(prv, size + ps + ns, lower_taken(prv));
    end
    push_free(prv);
    return prv;
  endfunction

  function automatic logic [WORD_W-1:0] smallest_fit(input logic [WORD_W-1:0] asize);
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] best;
    logic [WORD_W-1:0] best_sz;
    logic [WORD_W-1:0] s;
    int unsigned       steps;
    cur = list_head;
    best = 0;
    best_sz = 0;
    steps = 0;
    while (cur != 0 && steps < WALK_LIMIT) begin
      s = block_len(cur);
      if (s >= asize && (best == 0 || s < best_sz)) begin
        best = cur;
        best_sz = s;
      end
      cur = heap_rd(cur + 8);
      steps++;
    end
    return best;
  endfunction

  function automatic void split_block(input logic [WORD_W-1:0] bp, input logic [WORD_W-1:0] asize);
    logic [WORD_W-1:0] bs;
    logic [WORD_W-1:0] nxt;
    bs = block_len(bp);
    nxt = bp + bs;
    if (bs < asize + MIN_BLOCK) begin
      heap_wr(bp - 8, heap_rd(bp - 8) | 32'd1);
      unlink_free(bp);
      heap_wr(nxt - 8, heap_rd(nxt - 8) | 32'd2);
      return;
    end
    heap_wr(bp - 8, btag(asize, lower_taken(bp), 1'b1));
    unlink_free(bp);
    mark_free(bp + asize, bs - asize, 1'b1);
    push_free(bp + asize);
  endfunction

  function automatic logic [WORD_W-1:0] grow_brk(input logic [WORD_W-1:0] asize);
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] bp;
    size = asize > CHUNK_BYTES ? asize : CHUNK_BYTES;
    size = (size + 15) & ~32'd15;
    if ({32'd0, brk_end} + {32'd0, size} > 64'(HEAP_BYTES)) return 0;
    bp = brk_end;
    mark_free(bp, size, lower_taken(bp));
    heap_wr(bp + size - 8, btag('0, 1'b0, 1'b1));
    brk_end = brk_end + size;
    grown_bytes = grown_bytes + size[CNT_W-1:0];
    return coalesce(bp);
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < IMG_WORDS; i++) heap_words[i] = '0;
    heap_wr(8, btag(16, 1'b1, 1'b1));
    heap_wr(16, btag(16, 1'b1, 1'b1));
    heap_wr(24, btag(4096, 1'b1, 1'b0));
    heap_wr(4112, btag(4096, 1'b1, 1'b0));
    heap_wr(4120, btag('0, 1'b0, 1'b1));
    list_head = 32;
    brk_end = 4128;
    live_bytes = '0;
    grown_bytes = CNT_W'(4096);
  endfunction

  function automatic result_t serve_request(input logic rtype, input logic [REQ_SIZE_W-1:0] rsize,
                                            input logic [ADDR_W-1:0] baddr);
    result_t           r;
    logic [WORD_W-1:0] asize;
    logic [WORD_W-1:0] bp;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] h;
    logic [WORD_W-1:0] s;
    r = '0;
    a = WORD_W'(baddr);
    if (rtype == REQ_ALLOC) begin
      if (rsize != 0) begin
        asize = (WORD_W'(rsize) + 23) & ~32'd15;
        if (asize < MIN_BLOCK) asize = MIN_BLOCK;
        bp = smallest_fit(asize);
        if (bp == 0) bp = grow_brk(asize);
        if (bp != 0) begin
          split_block(bp, asize);
          live_bytes = live_bytes + CNT_W'(block_len(bp) - 8);
          r.payload_addr = bp[ADDR_W-1:0];
          r.ok = 1'b1;
        end
      end
    end else if (a[3:0] == 4'd0 && a >= 32 && a < brk_end) begin
      h = heap_rd(a - 8);
      s = h & ~32'd7;
      if (h[0] && s >= MIN_BLOCK && {32'd0, a} + {32'd0, s} <= {32'd0, brk_end}) begin
        mark_free(a, s, h[1]);
        heap_wr(a + s - 8, heap_rd(a + s - 8) & ~32'd2);
        live_bytes = live_bytes - CNT_W'(s - 8);
        void'(coalesce(a));
        r.ok = 1'b1;
      end
    end
    r.user_bytes = live_bytes;
    r.heap_bytes = grown_bytes;
    return r;
  endfunction

  task automatic send_request(input logic rtype, input logic [REQ_SIZE_W-1:0] rsize,
                              input logic [ADDR_W-1:0] baddr);
    int unsigned gap;
    result_t     r;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.req_type <= rtype;
    in_req.req_size <= rsize;
    in_req.block_addr <= baddr;
    forever begin
      @(negedge clk);
      if (in_req.ready) break;
    end
    @(posedge clk);
    r = serve_request(rtype, rsize, baddr);
    alloc_results.push_back(r);
    if (rtype == REQ_ALLOC && r.ok) live_blocks.push_back(32'(r.payload_addr));
  endtask

  task automatic alloc_block(input int unsigned bytes);
    send_request(REQ_ALLOC, REQ_SIZE_W'(bytes), '0);
  endtask

  task automatic free_live(input int unsigned idx);
    logic [31:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_request(REQ_FREE, '0, a[ADDR_W-1:0]);
  endtask

  task automatic drain_results();
    in_req.valid <= 1'b0;
    wait (alloc_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatches++;
  endtask

  task automatic test_size_extremes();
    alloc_block(0);
    alloc_block(1);
    alloc_block(24);
    alloc_block(25);
    alloc_block(4088);
    alloc_block(1048576);
    alloc_block(2097151);
    free_live(0);
    free_live(0);
  endtask

  task automatic test_coalescing();
    for (int i = 0; i < 5; i++) alloc_block(40);
    free_live(live_blocks.size() - 4);
    free_live(live_blocks.size() - 3);
    free_live(live_blocks.size() - 1);
    free_live(live_blocks.size() - 1);
  endtask

  task automatic test_rejected_frees();
    logic [31:0] a;
    alloc_block(100);
    a = live_blocks[live_blocks.size() - 1];
    free_live(live_blocks.size() - 1);
    send_request(REQ_FREE, '0, a[ADDR_W-1:0]);
    send_request(REQ_FREE, '0, 20'd40);
    send_request(REQ_FREE, '0, 20'd0);
    send_request(REQ_FREE, '0, 20'd16);
    send_request(REQ_FREE, '0, 20'hFFFF0);
    send_request(REQ_FREE, '0, 20'hFFFFF);
  endtask

  task automatic test_heap_full();
    alloc_block(1000000);
    alloc_block(100000);
    free_live(live_blocks.size() - 1);
  endtask

  task automatic test_output_backpressure();
    drain_results();
    rsp_hold = 600;
    for (int i = 0; i < 6; i++) alloc_block($urandom_range(1, 300));
    drain_results();
    for (int i = 0; i < 4; i++) free_live($urandom_range(0, live_blocks.size() - 1));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    logic [31:0] a;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        a = $urandom();
        if (a[3:0] == 4'd0 && a[ADDR_W-1:0] < brk_end) a[0] = 1'b1;
        send_request(REQ_FREE, REQ_SIZE_W'($urandom()), a[ADDR_W-1:0]);
      end else if (live_blocks.size() > 0 && (pick < 50 || live_blocks.size() > 80)) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (pick < 90) begin
        alloc_block($urandom_range(0, 600));
      end else if (pick < 98) begin
        alloc_block($urandom_range(600, 9000));
      end else begin
        alloc_block($urandom_range(9000, 1048576));
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (alloc_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 32'd1, 32'd0);
      end else begin
        want = alloc_results.pop_front();
        if (out_rsp.payload_addr !== want.payload_addr)
          report_mismatch("payload_addr", 32'(out_rsp.payload_addr), 32'(want.payload_addr));
        if (out_rsp.ok !== want.ok)
          report_mismatch("ok", 32'(out_rsp.ok), 32'(want.ok));
        if (out_rsp.user_bytes !== want.user_bytes)
          report_mismatch("user_bytes", 32'(out_rsp.user_bytes), 32'(want.user_bytes));
        if (out_rsp.heap_bytes !== want.heap_bytes)
          report_mismatch("heap_bytes", 32'(out_rsp.heap_bytes), 32'(want.heap_bytes));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL best_fit_heap_allocator_core");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    out_rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 11);
      if (rsp_hold > 0) begin
        n = rsp_hold;
        rsp_hold = 0;
      end
      if (n > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (out_rsp.valid) break;
      end
      @(posedge clk);
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.req_type = REQ_ALLOC;
    in_req.req_size = '0;
    in_req.block_addr = '0;
    mismatches = 0;
    quiet_cycles = 0;
    rsp_hold = 0;
    calm = 1'b0;
    heap_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_size_extremes();
    test_coalescing();
    test_rejected_frees();
    test_heap_full();
    test_output_backpressure();
    test_random_traffic();
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS best_fit_heap_allocator_core");
    end else begin
      $display("FAIL best_fit_heap_allocator_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bfha_pkg.sv
rtl/core/bfha_req_if.sv
rtl/core/bfha_rsp_if.sv
rtl/core/bfha_ram.sv
rtl/core/bfha_ctrl.sv
rtl/core/best_fit_heap_allocator_core.sv
bench/best_fit_heap_allocator_core_tb.sv
